// ===== hdl/mcd_pkg.sv =====
// Shared types, constants and a lookup function for the movie container deframer.
// No dependencies; used by every module under hdl/.
`default_nettype none

package mcd_pkg;

    // Highest major type + 1 that may be delivered (the mask covers 32 types at most)
    localparam int unsigned HANDLER_TYPES = 32;
    localparam int unsigned MASK_WIDTH    = 32;

    // Fixed framing figures
    localparam logic [4:0] FILE_HDR_LAST = 5'd25;
    localparam logic [4:0] FILE_HDR_LEN  = 5'd26;
    localparam logic [7:0] STOP_MAJOR    = 8'hFF;
    localparam logic [15:0] SEG_HDR_LEN  = 16'd4;

    // Parser phase, one-hot
    typedef enum logic [5:0] {
        PH_FILE  = 6'b000001,
        PH_CHUNK = 6'b000010,
        PH_SEG   = 6'b000100,
        PH_PAY   = 6'b001000,
        PH_SKIP  = 6'b010000,
        PH_ERR   = 6'b100000
    } phase_t;

    // Classification of each byte
    typedef enum logic [2:0] {
        KIND_FILE_HDR  = 3'd0,
        KIND_CHUNK_HDR = 3'd1,
        KIND_SEG_HDR   = 3'd2,
        KIND_PAY_DLV   = 3'd3,
        KIND_PAY_UNDLV = 3'd4,
        KIND_SKIPPED   = 3'd5,
        KIND_AFTER_ERR = 3'd6
    } kind_t;

    // One result item
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  byte_out;
        logic [7:0]  major;
        logic [7:0]  minor;
        logic [15:0] segment_length;
        logic [15:0] payload_index;
        logic        segment_ready;
        logic        delivered;
        logic        segment_end;
        logic        chunk_end;
        logic        header_error;
        logic        truncated;
    } result_t;

    // Handshake between the input register and the result register
    typedef struct packed {
        logic advance;   // result register can take an item this cycle
        logic fire;      // an item moves from input register to result register
    } flow_t;

    // Expected file header: signature, then 0x001A, 0x0100, 0x1133 little-endian
    function automatic logic [7:0] file_hdr_byte(input logic [4:0] idx);
        logic [7:0] val;
        begin
            case (idx)
                5'd0:    val = 8'h49;
                5'd1:    val = 8'h6E;
                5'd2:    val = 8'h74;
                5'd3:    val = 8'h65;
                5'd4:    val = 8'h72;
                5'd5:    val = 8'h70;
                5'd6:    val = 8'h6C;
                5'd7:    val = 8'h61;
                5'd8:    val = 8'h79;
                5'd9:    val = 8'h20;
                5'd10:   val = 8'h4D;
                5'd11:   val = 8'h56;
                5'd12:   val = 8'h45;
                5'd13:   val = 8'h20;
                5'd14:   val = 8'h46;
                5'd15:   val = 8'h69;
                5'd16:   val = 8'h6C;
                5'd17:   val = 8'h65;
                5'd18:   val = 8'h1A;
                5'd19:   val = 8'h00;
                5'd20:   val = 8'h1A;
                5'd21:   val = 8'h00;
                5'd22:   val = 8'h00;
                5'd23:   val = 8'h01;
                5'd24:   val = 8'h33;
                5'd25:   val = 8'h11;
                default: val = 8'h00;
            endcase
            return val;
        end
    endfunction

endpackage

`default_nettype wire

// ===== hdl/mcd_in_reg.sv =====
// Input register of the deframer: holds one accepted byte until the parser takes it.
// Depends on mcd_pkg (flow_t).
`default_nettype none

module mcd_in_reg (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           data_valid,
    output logic                data_stall,
    input  wire logic [7:0]     data_byte,
    input  wire logic           advance,
    output mcd_pkg::flow_t      flow,
    output logic [7:0]          held_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       load;

    // Stall only when a byte is held and the result side cannot move
    assign data_stall   = valid_reg && !advance;
    assign load         = data_valid && !data_stall;
    assign flow.advance = advance;
    assign flow.fire    = valid_reg && advance;
    assign held_byte    = byte_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (flow.fire)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= data_byte;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/mcd_parser.sv =====
// Parser of the deframer: framing state, handler mask and the per-byte classification.
// Depends on mcd_pkg (phase_t, kind_t, result_t, flow_t, file_hdr_byte).
`default_nettype none

module mcd_parser #(
    parameter int unsigned HANDLER_TYPES = mcd_pkg::HANDLER_TYPES
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_write,
    input  wire logic [mcd_pkg::MASK_WIDTH-1:0]       cfg_mask,
    input  wire mcd_pkg::flow_t                       flow,
    input  wire logic [7:0]                           b,
    output mcd_pkg::result_t                          res
);

    // Framing state
    mcd_pkg::phase_t                   phase_reg,    phase_next;
    logic [4:0]                        hc_reg,       hc_next;
    logic [15:0]                       clen_reg,     clen_next;
    logic [15:0]                       cpos_reg,     cpos_next;
    logic [1:0]                        shi_reg,      shi_next;
    logic [7:0]                        latch_reg,    latch_next;
    logic [15:0]                       slen_reg,     slen_next;
    logic [15:0]                       spos_reg,     spos_next;
    logic [7:0]                        major_reg,    major_next;
    logic [7:0]                        minor_reg,    minor_next;
    logic                              err_reg,      err_next;
    logic                              stopped_reg,  stopped_next;
    logic [mcd_pkg::MASK_WIDTH-1:0]    mask_reg;

    // Working values
    logic [4:0]  fidx;
    logic        mismatch;
    logic [15:0] rem_chunk;
    logic [15:0] rem_seg;
    logic        last;
    logic        short_tail;
    logic        enabled;

    // Major type enable from the mask
    always_comb
    begin
        enabled = ({24'd0, major_reg} < 32'(HANDLER_TYPES))
                  && (major_reg < 8'd32)
                  && mask_reg[major_reg[4:0]];
    end

    // Chunk and segment bookkeeping shared by the in-chunk phases, and the file header byte check
    assign rem_chunk  = (cpos_reg < clen_reg) ? (clen_reg - cpos_reg) : 16'd0;
    assign rem_seg    = (spos_reg < slen_reg) ? (slen_reg - spos_reg) : 16'd1;
    assign last       = (({1'b0, cpos_reg} + 17'd1) >= {1'b0, clen_reg});
    assign short_tail = (phase_reg == mcd_pkg::PH_SEG) && (shi_reg == 2'd0)
                        && (rem_chunk < mcd_pkg::SEG_HDR_LEN);
    assign fidx       = (hc_reg < mcd_pkg::FILE_HDR_LEN) ? hc_reg : mcd_pkg::FILE_HDR_LAST;
    assign mismatch   = (b != mcd_pkg::file_hdr_byte(fidx));

    // One byte step
    always_comb
    begin
        phase_next   = phase_reg;
        hc_next      = hc_reg;
        clen_next    = clen_reg;
        cpos_next    = cpos_reg;
        shi_next     = shi_reg;
        latch_next   = latch_reg;
        slen_next    = slen_reg;
        spos_next    = spos_reg;
        major_next   = major_reg;
        minor_next   = minor_reg;
        err_next     = err_reg;
        stopped_next = stopped_reg;

        res                = '0;
        res.kind           = mcd_pkg::KIND_AFTER_ERR;
        res.byte_out       = b;

        case (phase_reg)
            mcd_pkg::PH_FILE:
            begin
                res.kind = mcd_pkg::KIND_FILE_HDR;
                if (mismatch)
                begin
                    err_next = 1'b1;
                end
                if (fidx >= mcd_pkg::FILE_HDR_LAST)
                begin
                    hc_next    = 5'd0;
                    phase_next = (err_reg || mismatch) ? mcd_pkg::PH_ERR : mcd_pkg::PH_CHUNK;
                end
                else
                begin
                    hc_next = 5'(fidx + 5'd1);
                end
            end

            mcd_pkg::PH_CHUNK:
            begin
                res.kind = mcd_pkg::KIND_CHUNK_HDR;
                case (hc_reg[1:0])
                    2'd0:
                    begin
                        latch_next = b;
                    end
                    2'd1:
                    begin
                        clen_next = {b, latch_reg};
                    end
                    2'd3:
                    begin
                        cpos_next    = 16'd0;
                        shi_next     = 2'd0;
                        stopped_next = 1'b0;
                        if (clen_reg == 16'd0)
                        begin
                            res.chunk_end = 1'b1;
                        end
                        else
                        begin
                            phase_next = mcd_pkg::PH_SEG;
                        end
                    end
                    default:
                    begin
                        // chunk type bytes carry nothing we use
                    end
                endcase
                hc_next = {3'd0, 2'(hc_reg[1:0] + 2'd1)};
            end

            mcd_pkg::PH_SEG, mcd_pkg::PH_PAY, mcd_pkg::PH_SKIP:
            begin
                if (short_tail)
                begin
                    // fewer than four bytes left: skip the tail
                    stopped_next = 1'b1;
                    phase_next   = mcd_pkg::PH_SKIP;
                    res.kind     = mcd_pkg::KIND_SKIPPED;
                end
                else if (phase_reg == mcd_pkg::PH_SEG)
                begin
                    res.kind = mcd_pkg::KIND_SEG_HDR;
                    case (shi_reg)
                        2'd0:
                        begin
                            slen_next  = 16'd0;
                            major_next = 8'd0;
                            minor_next = 8'd0;
                            latch_next = b;
                        end
                        2'd1:
                        begin
                            slen_next = {b, latch_reg};
                        end
                        2'd2:
                        begin
                            major_next = b;
                            if (b == mcd_pkg::STOP_MAJOR)
                            begin
                                stopped_next = 1'b1;
                                phase_next   = mcd_pkg::PH_SKIP;
                            end
                        end
                        default:
                        begin
                            minor_next        = b;
                            res.segment_ready = 1'b1;
                            res.delivered     = enabled;
                            if (slen_reg == 16'd0)
                            begin
                                res.segment_end = 1'b1;
                            end
                            else if (last)
                            begin
                                res.segment_end = 1'b1;
                                res.truncated   = 1'b1;
                            end
                            else
                            begin
                                phase_next    = mcd_pkg::PH_PAY;
                                spos_next     = 16'd0;
                                res.truncated = (slen_reg > (rem_chunk - 16'd1));
                            end
                        end
                    endcase
                    shi_next           = 2'(shi_reg + 2'd1);
                    res.major          = major_next;
                    res.minor          = minor_next;
                    res.segment_length = slen_next;
                end
                else if (phase_reg == mcd_pkg::PH_PAY)
                begin
                    res.delivered      = enabled;
                    res.kind           = enabled ? mcd_pkg::KIND_PAY_DLV
                                                 : mcd_pkg::KIND_PAY_UNDLV;
                    res.major          = major_reg;
                    res.minor          = minor_reg;
                    res.segment_length = slen_reg;
                    res.payload_index  = spos_reg;
                    res.truncated      = (rem_seg > rem_chunk);
                    if ((rem_seg <= 16'd1) || last)
                    begin
                        res.segment_end = 1'b1;
                        phase_next      = mcd_pkg::PH_SEG;
                        shi_next        = 2'd0;
                    end
                    else
                    begin
                        spos_next = 16'(spos_reg + 16'd1);
                    end
                end
                else
                begin
                    res.kind = mcd_pkg::KIND_SKIPPED;
                end

                // chunk position advances on every in-chunk byte
                cpos_next = 16'(cpos_reg + 16'd1);
                if (last)
                begin
                    res.chunk_end = 1'b1;
                    phase_next    = mcd_pkg::PH_CHUNK;
                    hc_next       = 5'd0;
                end
            end

            default:
            begin
                res.kind = mcd_pkg::KIND_AFTER_ERR;
            end
        endcase

        res.header_error = err_next;
    end

    // State update on each byte that moves through
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= mcd_pkg::PH_FILE;
            hc_reg      <= 5'd0;
            clen_reg    <= 16'd0;
            cpos_reg    <= 16'd0;
            shi_reg     <= 2'd0;
            latch_reg   <= 8'd0;
            slen_reg    <= 16'd0;
            spos_reg    <= 16'd0;
            major_reg   <= 8'd0;
            minor_reg   <= 8'd0;
            err_reg     <= 1'b0;
            stopped_reg <= 1'b0;
        end
        else if (flow.fire)
        begin
            phase_reg   <= phase_next;
            hc_reg      <= hc_next;
            clen_reg    <= clen_next;
            cpos_reg    <= cpos_next;
            shi_reg     <= shi_next;
            latch_reg   <= latch_next;
            slen_reg    <= slen_next;
            spos_reg    <= spos_next;
            major_reg   <= major_next;
            minor_reg   <= minor_next;
            err_reg     <= err_next;
            stopped_reg <= stopped_next;
        end
    end

    // Handler mask register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else if (cfg_write)
        begin
            mask_reg <= cfg_mask;
        end
    end

    // Checks
    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg |=> err_reg)
        else $error("header error flag cleared");

    a_chunk_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == mcd_pkg::PH_CHUNK) |-> (hc_reg < 5'd4))
        else $error("chunk header count out of range");

    a_ready_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (flow.fire && res.segment_ready) |-> (res.kind == mcd_pkg::KIND_SEG_HDR))
        else $error("segment ready outside a segment header");

    a_trunc_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (flow.fire && res.truncated) |->
            (res.segment_ready || res.kind == mcd_pkg::KIND_PAY_DLV
             || res.kind == mcd_pkg::KIND_PAY_UNDLV))
        else $error("truncation flagged on a byte outside a segment");

    a_stop_skip: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == mcd_pkg::PH_SKIP) |-> stopped_reg)
        else $error("skipping without a stopped chunk");

endmodule

`default_nettype wire

// ===== hdl/mcd_out_reg.sv =====
// Result register of the deframer: holds one result item until the receiver takes it.
// Depends on mcd_pkg (result_t, flow_t).
`default_nettype none

module mcd_out_reg (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire mcd_pkg::flow_t     flow,
    input  wire mcd_pkg::result_t   res_in,
    input  wire logic               result_stall,
    output logic                    result_valid,
    output logic                    advance,
    output mcd_pkg::result_t        res_out
);

    logic             valid_reg;
    logic             valid_next;
    mcd_pkg::result_t res_reg;

    // Free when empty or when the held item leaves this cycle
    assign advance      = !valid_reg || !result_stall;
    assign result_valid = valid_reg;
    assign res_out      = res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (flow.advance)
        begin
            valid_next = flow.fire;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (flow.fire)
        begin
            res_reg <= res_in;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/movie_container_deframer_top.sv =====
// Top level of the movie container deframer: input register, parser, result register.
// Depends on mcd_pkg, mcd_in_reg, mcd_parser and mcd_out_reg.
`default_nettype none

// Takes one byte of a chunked movie file per item and returns one tagged result item per
// byte: file header check (sticky error), chunk and segment framing, payload tagging by the
// handler mask. Throughput is one item per clock while result_stall is low. A byte is held
// in the input register and its result is then registered in the result register, which
// presents it until it is taken; all framing counters are updated in a single pass of
// logic between the two registers. A stalled result holds the input register, and the
// input stalls once that register is full too. handler_mask is written through the cfg
// channel (always ready) and applies from the next byte on.

module movie_container_deframer_top #(
    parameter int unsigned HANDLER_TYPES = mcd_pkg::HANDLER_TYPES
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] handler_mask,
    // input items
    input  wire logic        data_valid,
    output logic             data_stall,
    input  wire logic [7:0]  data_byte,
    // result items
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic [2:0]       kind,
    output logic [7:0]       byte_out,
    output logic [7:0]       major,
    output logic [7:0]       minor,
    output logic [15:0]      segment_length,
    output logic [15:0]      payload_index,
    output logic             segment_ready,
    output logic             delivered,
    output logic             segment_end,
    output logic             chunk_end,
    output logic             header_error,
    output logic             truncated
);

    mcd_pkg::flow_t   flow;
    mcd_pkg::result_t step_res;
    mcd_pkg::result_t out_res;
    logic [7:0]       held_byte;
    logic             advance;

    assign cfg_ready = 1'b1;

    mcd_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_valid (data_valid),
        .data_stall (data_stall),
        .data_byte  (data_byte),
        .advance    (advance),
        .flow       (flow),
        .held_byte  (held_byte)
    );

    mcd_parser #(
        .HANDLER_TYPES (HANDLER_TYPES)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_mask  (handler_mask),
        .flow      (flow),
        .b         (held_byte),
        .res       (step_res)
    );

    mcd_out_reg u_out_reg (
        .clk          (clk),
        .rst_n        (rst_n),
        .flow         (flow),
        .res_in       (step_res),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .advance      (advance),
        .res_out      (out_res)
    );

    // Result fields to ports
    assign kind           = out_res.kind;
    assign byte_out       = out_res.byte_out;
    assign major          = out_res.major;
    assign minor          = out_res.minor;
    assign segment_length = out_res.segment_length;
    assign payload_index  = out_res.payload_index;
    assign segment_ready  = out_res.segment_ready;
    assign delivered      = out_res.delivered;
    assign segment_end    = out_res.segment_end;
    assign chunk_end      = out_res.chunk_end;
    assign header_error   = out_res.header_error;
    assign truncated      = out_res.truncated;

endmodule

`default_nettype wire
